>>> sv/kmcd_pkg.sv
// shared types, constants and helper functions for the key multi-click detector
package kmcd_pkg;

    localparam int TICK_WIDTH  = 16;
    localparam int COUNT_WIDTH = 8;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int HOLD_OUT_W = 16;
    localparam int CNT_OUT_W  = 8;

    localparam int TICK_CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
    localparam int HOLD_CMP_W = (TICK_WIDTH > HOLD_OUT_W) ? TICK_WIDTH : HOLD_OUT_W;
    localparam int CNT_CMP_W  = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MIN_TICKS = 1'b1;

    localparam logic [CFG_W-1:0] RELEASE_TICKS_RST   = 16'd20;
    localparam logic [CFG_W-1:0] PRESS_MIN_TICKS_RST = 16'h0001;

    localparam logic OP_SCAN    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    localparam logic [2:0] HIST_HIGH_LOW_HIGH = 3'b101;

    typedef struct packed {
        logic op;
        logic level;
    } t_in_word;

    typedef struct packed {
        logic                  key_active;
        logic [CNT_OUT_W-1:0]  press_count;
        logic [HOLD_OUT_W-1:0] hold_ticks;
        logic                  event_fired;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] release_ticks;
        logic [CFG_W-1:0] press_min_ticks;
    } t_cfg;

    function automatic logic [TICK_WIDTH-1:0] tick_inc(input logic [TICK_WIDTH-1:0] v);
        return (v == {TICK_WIDTH{1'b1}}) ? v : v + TICK_WIDTH'(1);
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == {COUNT_WIDTH{1'b1}}) ? v : v + COUNT_WIDTH'(1);
    endfunction

    function automatic logic [HOLD_OUT_W-1:0] hold_clamp(input logic [TICK_WIDTH-1:0] v);
        logic [HOLD_CMP_W-1:0] x;
        x = HOLD_CMP_W'(v);
        if (x > HOLD_CMP_W'({HOLD_OUT_W{1'b1}})) begin
            return {HOLD_OUT_W{1'b1}};
        end
        return x[HOLD_OUT_W-1:0];
    endfunction

    function automatic logic [CNT_OUT_W-1:0] count_clamp(input logic [COUNT_WIDTH-1:0] v);
        logic [CNT_CMP_W-1:0] x;
        x = CNT_CMP_W'(v);
        if (x > CNT_CMP_W'({CNT_OUT_W{1'b1}})) begin
            return {CNT_OUT_W{1'b1}};
        end
        return x[CNT_OUT_W-1:0];
    endfunction

endpackage

>>> sv/kmcd_core.sv
// level tracker and press state; the next state is combinational and is registered on i_step
module kmcd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  kmcd_pkg::t_in_word  i_word,
    input  kmcd_pkg::t_cfg      i_cfg,
    output kmcd_pkg::t_out_word o_result
);

    logic                               r_last, n_last;
    logic [kmcd_pkg::TICK_WIDTH-1:0]    r_run, n_run;
    logic                               r_ep, n_ep;
    logic [2:0]                         r_hist, n_hist;
    logic                               r_active, n_active;
    logic [kmcd_pkg::COUNT_WIDTH-1:0]   r_total, n_total;
    logic [kmcd_pkg::TICK_WIDTH-1:0]    r_hold, n_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= 1'b0;
            r_run    <= '0;
            r_ep     <= 1'b0;
            r_hist   <= '0;
            r_active <= 1'b0;
            r_total  <= '0;
            r_hold   <= '0;
        end else if (i_step) begin
            r_last   <= n_last;
            r_run    <= n_run;
            r_ep     <= n_ep;
            r_hist   <= n_hist;
            r_active <= n_active;
            r_total  <= n_total;
            r_hold   <= n_hold;
        end
    end

    always_comb begin
        logic hold_out_sel;
        hold_out_sel = 1'b0;
        n_last   = r_last;
        n_run    = r_run;
        n_ep     = r_ep;
        n_hist   = r_hist;
        n_active = r_active;
        n_total  = r_total;
        n_hold   = r_hold;

        if (i_word.op == kmcd_pkg::OP_CONSUME) begin
            if (r_active) begin
                n_active = 1'b0;
                n_total  = '0;
                n_hold   = '0;
            end
        end else begin
            hold_out_sel = 1'b1;
            // edge tracking
            if (i_word.level != r_last) begin
                n_last = i_word.level;
                n_run  = '0;
                n_ep   = 1'b1;
                n_hist = {i_word.level, r_hist[2], r_hist[1]};
            end else begin
                n_run = kmcd_pkg::tick_inc(r_run);
            end

            if (!i_word.level) begin
                if (kmcd_pkg::TICK_CMP_W'(n_run) >=
                    kmcd_pkg::TICK_CMP_W'(i_cfg.release_ticks)) begin
                    n_active = 1'b0;
                    n_total  = '0;
                    n_hold   = '0;
                    n_run    = '0;
                end
            end else if (r_active) begin
                if (n_ep && (n_hist == kmcd_pkg::HIST_HIGH_LOW_HIGH)) begin
                    n_total = kmcd_pkg::count_inc(r_total);
                    n_ep    = 1'b0;
                    n_hold  = kmcd_pkg::tick_inc(n_run);
                end else begin
                    n_hold  = kmcd_pkg::tick_inc(r_hold);
                end
            end else if (kmcd_pkg::TICK_CMP_W'(n_run) >
                         kmcd_pkg::TICK_CMP_W'(i_cfg.press_min_ticks)) begin
                n_active = 1'b1;
                n_total  = kmcd_pkg::COUNT_WIDTH'(1);
                n_hold   = n_run;
            end
        end

        // scan reports the new state, consume the old one
        o_result.key_active  = hold_out_sel ? n_active : r_active;
        o_result.press_count = kmcd_pkg::count_clamp(hold_out_sel ? n_total : r_total);
        o_result.hold_ticks  = kmcd_pkg::hold_clamp(hold_out_sel ? n_hold : r_hold);
        o_result.event_fired = (i_word.op == kmcd_pkg::OP_CONSUME) && r_active;
    end

endmodule

>>> sv/key_multi_click_detector_top.sv
// top level: input register, press tracker, result register and config registers
// path: an accepted word is held in the input register, then its result in the result register
// throughput: one word per cycle while the output is not stalled; the tracker state updates on each step
// reset: synchronous active low; clears the tracker state and valid flags,
// release_ticks returns to 20 and press_min_ticks to 1
module key_multi_click_detector_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kmcd_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kmcd_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [kmcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [kmcd_pkg::CFG_W-1:0]          i_cfg_data
);

    logic                r_in_vld;
    kmcd_pkg::t_in_word  r_in_word;
    logic                r_out_vld;
    kmcd_pkg::t_out_word r_out_word;
    kmcd_pkg::t_out_word core_result;
    kmcd_pkg::t_cfg      r_cfg;
    logic                out_free;
    logic                step;

    assign out_free   = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_ticks   <= kmcd_pkg::RELEASE_TICKS_RST;
            r_cfg.press_min_ticks <= kmcd_pkg::PRESS_MIN_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmcd_pkg::CFG_RELEASE_TICKS:   r_cfg.release_ticks   <= i_cfg_data;
                kmcd_pkg::CFG_PRESS_MIN_TICKS: r_cfg.press_min_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    kmcd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_word   (r_in_word),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= core_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

>>> sv/kmcd_checker.sv
// port-level checker for the key multi-click detector, bound to the top level
module kmcd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input kmcd_pkg::t_out_word o_out_word
);

    // an event only comes from an active press
    a_event_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_fired |-> o_out_word.key_active)
        else $error("event fired without active press");

    // inactive press state carries no count and no hold time
    a_idle_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.key_active |->
            (o_out_word.press_count == '0) && (o_out_word.hold_ticks == '0))
        else $error("press state not cleared while inactive");

    // an active press has counted at least one press
    a_active_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.key_active |-> (o_out_word.press_count != '0))
        else $error("active press with zero count");

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

endmodule

bind key_multi_click_detector_top kmcd_checker u_kmcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
